// ----- hw/rtl/wbps_pkg.sv -----
// -----------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Shared types, register indexes and status codes.
// -----------------------------------------------------------------------------
package wbps_pkg;

   localparam int PAT_BYTES = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int VALUE_W = 24;

   typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_type;
   typedef logic [1:0] status_type;

   localparam status_type STATUS_FOUND = 2'd0;
   localparam status_type STATUS_NOMATCH = 2'd1;
   localparam status_type STATUS_OUTSIDE = 2'd2;
   localparam status_type STATUS_BADPAT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_PAT_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CARE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PLEN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TOFF = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_WMODE = 3'd7;

   typedef struct packed {
      logic clear;
      logic shift;
   } chain_ctrl_type;

endpackage

// ----- hw/rtl/wbps_cell.sv -----
// -----------------------------------------------------------------------------
// Match cell
// Holds whether pattern bytes up to its own position matched ending at the
// latest code byte, and hands that flag on to the next cell.
// -----------------------------------------------------------------------------
module wbps_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  wbps_pkg::chain_ctrl_type ctrl,
   input  logic [7:0]               code_byte,
   input  logic [7:0]               pat_byte,
   input  logic                     care,
   input  logic                     prev_match,
   output logic                     match
);
   import wbps_pkg::*;

   logic match_ff;
   logic match_in;

   always_comb begin
      match_in = match_ff;
      if (ctrl.clear) begin
         match_in = 1'b0;
      end else if (ctrl.shift) begin
         match_in = prev_match && (!care || (code_byte == pat_byte));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match = match_ff;

endmodule

// ----- hw/rtl/wbps_match_chain.sv -----
// -----------------------------------------------------------------------------
// Match chain
// A row of match cells; cell i reports a match of pattern bytes 0 to i
// ending at the most recent code byte.
// -----------------------------------------------------------------------------
module wbps_match_chain #(
   parameter int CELLS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  wbps_pkg::chain_ctrl_type ctrl,
   input  logic [7:0]               code_byte,
   input  wbps_pkg::pat_bytes_type  pattern,
   input  logic [31:0]              care_mask,
   output logic [CELLS-1:0]         match
);
   import wbps_pkg::*;

   logic [CELLS-1:0] prev;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev[i] = 1'b1;
      end else begin : g_body
         assign prev[i] = match[i-1];
      end
      wbps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .code_byte  (code_byte),
         .pat_byte   (pattern[i]),
         .care       (care_mask[i]),
         .prev_match (prev[i]),
         .match      (match[i])
      );
   end

endmodule

// ----- hw/rtl/wildcard_byte_pattern_scanner.sv -----
// -----------------------------------------------------------------------------
// Wildcard byte pattern scanner
// Stores a code image and finds the first offset matching a masked pattern.
// -----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+-----------------------------------
//  req      | start & !busy        | req_code_byte, req_final_byte
//  rsp      | rsp_valid (strobe)   | rsp_scan_value, rsp_scan_status
//  csr      | csr_valid & ready    | csr_index, csr_wdata
//
// Each byte of an image, up to CODE_MAX bytes, is stored through the memory write port.
// After the final byte the image is read back one byte a cycle into the
// chain of match cells: the scan result follows, then the address is
// adjusted by the offset register and range checked, and in word mode the
// word is read byte by byte through the single read port.
// Reset clears the state, the configuration and the byte count; the memory is not cleared.
// The receiver cannot stall, so results leave as a one-cycle strobe.
module wildcard_byte_pattern_scanner #(
   parameter int CODE_MAX = 65536,
   parameter int PATTERN_MAX = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [7:0]                          req_code_byte,
   input  logic                                req_final_byte,
   output logic                                rsp_valid,
   output logic [wbps_pkg::VALUE_W-1:0]        rsp_scan_value,
   output wbps_pkg::status_type                rsp_scan_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import wbps_pkg::*;

   localparam int AW = $clog2(CODE_MAX);
   localparam int LW = AW + 1;
   localparam int PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int SW = ((AW > 17) ? AW : 17) + 2;

   typedef enum logic [2:0] {
      ST_LOAD, ST_CHECK, ST_SCAN, ST_ADDR, ST_RANGE, ST_WORD
   } state_type;

   state_type state_ff;
   logic [3:0][63:0] pattern_ff;
   logic [31:0] care_ff;
   logic [5:0] plen_ff;
   logic signed [16:0] toff_ff;
   logic wmode_ff;

   logic [7:0] mem [CODE_MAX];
   logic [7:0] mem_q;
   logic [AW-1:0] rd_addr;

   logic [LW-1:0] len_ff;
   logic [LW-1:0] issue_ff;
   logic data_vld_ff;
   logic [AW-1:0] data_idx_ff;
   logic cell_vld_ff;
   logic [AW-1:0] cell_idx_ff;
   logic [AW-1:0] where;
   logic signed [SW-1:0] adj_ff;
   logic [AW-1:0] addr_ff;
   logic [1:0] k_ff;
   logic rng_ff;
   logic [VALUE_W-1:0] word_ff;
   logic rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   status_type rsp_status_ff;

   chain_ctrl_type ctrl;
   logic [PATTERN_MAX-1:0] match;
   logic [PIW-1:0] last_cell;
   logic hit;
   logic accept;
   logic issue;
   logic [7:0] word_byte;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_LOAD);
   assign csr_ready = 1'b1;
   assign issue = (state_ff == ST_SCAN) && (issue_ff < len_ff);
   assign last_cell = PIW'(plen_ff - 6'd1);
   assign hit = cell_vld_ff && match[last_cell];
   assign where = cell_idx_ff - AW'(plen_ff - 6'd1);
   assign word_byte = rng_ff ? mem_q : 8'd0;

   assign ctrl.clear = (state_ff == ST_CHECK);
   assign ctrl.shift = (state_ff == ST_SCAN) && data_vld_ff;

   always_comb begin
      if (state_ff == ST_WORD) begin
         rd_addr = addr_ff + AW'(k_ff);
      end else begin
         rd_addr = issue_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (len_ff < LW'(CODE_MAX))) begin
         mem[len_ff[AW-1:0]] <= req_code_byte;
      end
   end

   always_ff @(posedge clock) begin
      mem_q <= mem[rd_addr];
   end

   wbps_match_chain #(
      .CELLS (PATTERN_MAX)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .code_byte (mem_q),
      .pattern   (pat_bytes_type'(pattern_ff)),
      .care_mask (care_ff),
      .match     (match)
   );

   // Configuration registers; written by users only while the block is idle (unchecked).
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         care_ff <= '0;
         plen_ff <= '0;
         toff_ff <= '0;
         wmode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PAT_A: pattern_ff[0] <= csr_wdata;
            REG_PAT_B: pattern_ff[1] <= csr_wdata;
            REG_PAT_C: pattern_ff[2] <= csr_wdata;
            REG_PAT_D: pattern_ff[3] <= csr_wdata;
            REG_CARE: care_ff <= csr_wdata[31:0];
            REG_PLEN: plen_ff <= csr_wdata[5:0];
            REG_TOFF: toff_ff <= signed'(csr_wdata[16:0]);
            REG_WMODE: wmode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         len_ff <= '0;
         issue_ff <= '0;
         data_vld_ff <= 1'b0;
         cell_vld_ff <= 1'b0;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_status_ff <= STATUS_FOUND;
         rsp_value_ff <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         data_vld_ff <= issue;
         data_idx_ff <= issue_ff[AW-1:0];
         cell_vld_ff <= ctrl.shift;
         cell_idx_ff <= data_idx_ff;
         unique case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (len_ff < LW'(CODE_MAX)) begin
                     len_ff <= len_ff + LW'(1);
                  end
                  if (req_final_byte) begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               issue_ff <= '0;
               if ((plen_ff == 6'd0) || (plen_ff > 6'(PATTERN_MAX))) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= STATUS_BADPAT;
                  rsp_value_ff <= '0;
                  len_ff <= '0;
                  state_ff <= ST_LOAD;
               end else if (len_ff < LW'(plen_ff)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= STATUS_NOMATCH;
                  rsp_value_ff <= '0;
                  len_ff <= '0;
                  state_ff <= ST_LOAD;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (issue) begin
                  issue_ff <= issue_ff + LW'(1);
               end
               // A match at offset zero ends the search as a miss.
               if (hit && (where == '0)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= STATUS_NOMATCH;
                  rsp_value_ff <= '0;
                  len_ff <= '0;
                  state_ff <= ST_LOAD;
               end else if (hit) begin
                  adj_ff <= SW'(signed'({1'b0, where})) + SW'(toff_ff);
                  state_ff <= ST_ADDR;
               end else if (cell_vld_ff && (({1'b0, cell_idx_ff} + LW'(1)) == len_ff)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= STATUS_NOMATCH;
                  rsp_value_ff <= '0;
                  len_ff <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_ADDR: begin
               state_ff <= ST_RANGE;
            end
            ST_RANGE: begin
               if ((adj_ff < 0) || (adj_ff >= SW'(signed'({1'b0, len_ff})))) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= STATUS_OUTSIDE;
                  rsp_value_ff <= '0;
                  len_ff <= '0;
                  state_ff <= ST_LOAD;
               end else if (wmode_ff) begin
                  addr_ff <= adj_ff[AW-1:0];
                  k_ff <= '0;
                  state_ff <= ST_WORD;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= STATUS_FOUND;
                  rsp_value_ff <= VALUE_W'(adj_ff[AW-1:0]);
                  len_ff <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_WORD: begin
               // Bytes beyond the image read as zero.
               rng_ff <= (({1'b0, addr_ff} + LW'(k_ff)) < len_ff);
               k_ff <= k_ff + 2'd1;
               if (k_ff != 2'd0) begin
                  word_ff <= {word_byte, word_ff[VALUE_W-1:8]};
               end
               if (k_ff == 2'd3) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= STATUS_FOUND;
                  rsp_value_ff <= {word_byte, word_ff[VALUE_W-1:8]};
                  len_ff <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_scan_value = rsp_value_ff;
   assign rsp_scan_status = rsp_status_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while still busy");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_scan_status != STATUS_FOUND)) |-> (rsp_scan_value == '0))
      else $error("failure result carries a non-zero value");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_final_byte) |=> !rsp_valid)
      else $error("result without a final byte");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(CODE_MAX))
      else $error("byte count beyond the store");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Wildcard byte pattern scanner testbench
// Streams code images into the scanner, mirrors the stored image and the
// registers, and checks every scan result against a behavioural predictor or the directed table.
// -----------------------------------------------------------------------------
module tb;
   import wbps_pkg::*;

   localparam int IMAGE_MAX = 65536;
   localparam int PHASE_BYTES = 534;
   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      logic [23:0] value;
      status_type  status;
   } scan_word_type;

   typedef struct {
      bit            is_csr;
      logic [2:0]    idx;
      logic [63:0]   data;
      logic [7:0]    code;
      bit            last;
      bit            typed;
      scan_word_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [7:0] req_code_byte = '0;
   logic req_final_byte = 1'b0;
   logic rsp_valid;
   logic [23:0] rsp_scan_value;
   status_type rsp_scan_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the registers and of the image held by the block.
   logic [255:0] pat_bits = '0;
   logic [31:0] care = '0;
   logic [5:0] plen = '0;
   logic [16:0] toff = '0;
   logic wmode = 1'b0;
   logic [7:0] image_mem [0:IMAGE_MAX-1];
   int unsigned image_len = 0;

   scan_word_type pending_scans[$];
   dir_row_type dir_rows[$];
   int errors = 0;
   int quiet = 0;
   int idle_pct = 0;

   always #1 clock = ~clock;

   wildcard_byte_pattern_scanner u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_code_byte(req_code_byte), .req_final_byte(req_final_byte),
      .rsp_valid(rsp_valid), .rsp_scan_value(rsp_scan_value),
      .rsp_scan_status(rsp_scan_status), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic logic [7:0] image_byte(int unsigned addr);
      if (addr >= image_len || addr >= IMAGE_MAX) return 8'h00;
      return image_mem[addr];
   endfunction

   function automatic scan_word_type predict_scan();
      scan_word_type r;
      int unsigned off, i, last, hit_at;
      bit hit, ok;
      int disp, adj;
      r.value = '0;
      r.status = STATUS_NOMATCH;
      hit = 0;
      hit_at = 0;
      if (plen == 0 || plen > 32) begin
         r.status = STATUS_BADPAT;
         return r;
      end
      if (image_len < plen) return r;
      last = image_len - plen;
      for (off = 0; off <= last && !hit; off++) begin
         ok = 1;
         for (i = 0; i < plen; i++) begin
            if (care[i] && image_byte(off + i) != pat_bits[i*8 +: 8]) begin
               ok = 0;
               break;
            end
         end
         if (ok) begin
            hit = 1;
            hit_at = off;
         end
      end
      // A match at offset zero is reported as no match at all.
      if (!hit || hit_at == 0) return r;
      disp = toff[16] ? int'(toff[15:0]) - 65536 : int'(toff[15:0]);
      adj = int'(hit_at) + disp;
      if (adj < 0 || adj >= int'(image_len)) begin
         r.status = STATUS_OUTSIDE;
         return r;
      end
      if (wmode) r.value = {image_byte(adj + 2), image_byte(adj + 1), image_byte(adj)};
      else r.value = adj[23:0];
      r.status = STATUS_FOUND;
      return r;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_PAT_A: pat_bits[63:0] = data;
         REG_PAT_B: pat_bits[127:64] = data;
         REG_PAT_C: pat_bits[191:128] = data;
         REG_PAT_D: pat_bits[255:192] = data;
         REG_CARE: care = data[31:0];
         REG_PLEN: plen = data[5:0];
         REG_TOFF: toff = data[16:0];
         REG_WMODE: wmode = data[0];
         default: ;
      endcase
      // Keep the next write's drive apart from this deassertion.
      @(posedge clock);
   endtask

   // Waits for the outstanding scan result, then lets the block settle.
   task automatic wait_idle();
      while (pending_scans.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic send_byte(logic [7:0] b, bit last, bit typed, scan_word_type want);
      scan_word_type exp_word;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_code_byte <= b;
      req_final_byte <= last;
      do @(posedge clock); while (busy);
      if (image_len < IMAGE_MAX) begin
         image_mem[image_len] = b;
         image_len++;
      end
      if (last) begin
         exp_word = typed ? want : predict_scan();
         pending_scans = {pending_scans, exp_word};
         image_len = 0;
         start <= 1'b0;
         // The block is busy scanning here, so waiting costs nothing.
         @(posedge clock);
      end
   endtask

   task automatic random_config();
      int r;
      logic [31:0] c;
      logic [16:0] t;
      for (int k = 0; k < 4; k++) write_reg(3'(k), {$urandom, $urandom});
      r = $urandom_range(0, 99);
      if (r < 5) write_reg(REG_PLEN, 64'd0);
      else if (r < 10) write_reg(REG_PLEN, 64'($urandom_range(33, 63)));
      else if (r < 60) write_reg(REG_PLEN, 64'($urandom_range(1, 4)));
      else write_reg(REG_PLEN, 64'($urandom_range(1, 32)));
      r = $urandom_range(0, 99);
      c = (r < 10) ? 32'h0 : (r < 25) ? 32'hFFFF_FFFF : $urandom;
      write_reg(REG_CARE, 64'(c));
      r = $urandom_range(0, 99);
      if (r < 70) t = 17'($urandom_range(0, 16)) - 17'd8;
      else if (r < 80) t = $urandom_range(0, 1) ? 17'h10000 : 17'h0FFFF;
      else t = 17'($urandom);
      write_reg(REG_TOFF, 64'(t));
      write_reg(REG_WMODE, 64'($urandom_range(0, 1)));
   endtask

   // One image of random bytes, usually with the pattern planted in it.
   task automatic random_image(output int unsigned n);
      logic [7:0] img[];
      int unsigned at;
      scan_word_type none;
      none = '{24'h0, STATUS_FOUND};
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      img = new[n];
      for (int unsigned k = 0; k < n; k++)
         img[k] = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 3)) : 8'($urandom);
      if (plen >= 1 && plen <= 32 && n >= plen && $urandom_range(0, 9) < 7) begin
         at = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, n - plen);
         for (int unsigned k = 0; k < plen; k++) img[at + k] = pat_bits[k*8 +: 8];
      end
      for (int unsigned k = 0; k < n; k++) send_byte(img[k], k == n - 1, 0, none);
   endtask

   task automatic add_csr(logic [2:0] idx, logic [63:0] data);
      dir_row_type row;
      row = '{1, idx, data, 8'h00, 0, 0, '{24'h0, STATUS_FOUND}};
      dir_rows = {dir_rows, row};
   endtask

   task automatic add_byte(logic [7:0] b, bit last = 0, bit typed = 0,
                           logic [23:0] v = 0, status_type s = STATUS_FOUND);
      dir_row_type row;
      row = '{0, REG_PAT_A, 64'h0, b, last, typed, '{v, s}};
      dir_rows = {dir_rows, row};
   endtask

   // Result checker: the receiver never stalls, so every strobe is one word.
   always @(posedge clock) begin
      scan_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_scans.size() == 0) begin
            $error("unexpected scan result value=%h status=%0d",
                   rsp_scan_value, rsp_scan_status);
            errors++;
         end else begin
            want = pending_scans.pop_front();
            if (rsp_scan_value !== want.value) begin
               $error("scan_value expected %h actual %h", want.value, rsp_scan_value);
               errors++;
            end
            if (rsp_scan_status !== want.status) begin
               $error("scan_status expected %0d actual %0d", want.status, rsp_scan_status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready) || rsp_valid) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned sent, n;

      // Directed table: reset state, register extremes and each corner case.
      add_byte(8'h00, 1, 1, 24'h0, STATUS_BADPAT);
      add_csr(REG_PAT_A, 64'hFFFF_FFFF_FFFF_FFAB);
      add_csr(REG_PAT_B, '1);
      add_csr(REG_PAT_C, '0);
      add_csr(REG_PAT_D, '1);
      add_csr(REG_CARE, 64'h1);
      add_csr(REG_PLEN, 64'd1);
      add_csr(REG_TOFF, 64'h0);
      add_csr(REG_WMODE, 64'h0);
      add_byte(8'hAB, 1, 1, 24'h0, STATUS_NOMATCH);
      add_byte(8'h00); add_byte(8'h11); add_byte(8'hAB);
      add_byte(8'h22, 1, 1, 24'd2, STATUS_FOUND);
      add_csr(REG_WMODE, 64'h1);
      add_byte(8'h00); add_byte(8'h11); add_byte(8'hAB); add_byte(8'h22);
      add_byte(8'h33, 1, 1, 24'h3322AB, STATUS_FOUND);
      add_byte(8'h00); add_byte(8'hAB);
      add_byte(8'h44, 1, 1, 24'h0044AB, STATUS_FOUND);
      add_csr(REG_TOFF, 64'h1FFFE);
      add_byte(8'h00); add_byte(8'hAB, 1, 1, 24'h0, STATUS_OUTSIDE);
      add_csr(REG_TOFF, 64'h0FFFF);
      add_byte(8'h00); add_byte(8'hAB, 1, 1, 24'h0, STATUS_OUTSIDE);
      add_csr(REG_TOFF, 64'h10000);
      add_byte(8'h00); add_byte(8'hAB, 1, 1, 24'h0, STATUS_OUTSIDE);
      add_csr(REG_PLEN, 64'd63);
      add_byte(8'hAB, 1, 1, 24'h0, STATUS_BADPAT);
      add_csr(REG_PLEN, 64'd32);
      add_csr(REG_CARE, 64'hFFFF_FFFF);
      add_byte(8'h05, 1, 1, 24'h0, STATUS_NOMATCH);
      add_csr(REG_CARE, 64'h0);
      add_csr(REG_PLEN, 64'd2);
      add_byte(8'h01); add_byte(8'hFF, 1, 1, 24'h0, STATUS_NOMATCH);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 38;
      foreach (dir_rows[k]) begin
         if (dir_rows[k].is_csr) begin
            wait_idle();
            write_reg(dir_rows[k].idx, dir_rows[k].data);
         end else begin
            send_byte(dir_rows[k].code, dir_rows[k].last, dir_rows[k].typed,
                      dir_rows[k].want);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 38 : (ph == 1) ? 82 : 0;
         sent = 0;
         while (sent < PHASE_BYTES) begin
            if ($urandom_range(0, 2) == 0) begin
               wait_idle();
               random_config();
            end
            random_image(n);
            sent += n;
         end
      end

      while (pending_scans.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
